>>> rtl/core/pid_aw_pkg.sv
// ----------------------------------------------------------------------------
// pid_aw_pkg
// Shared widths and configuration register indexes of the PID controller
// with integral clamp.
// ----------------------------------------------------------------------------
package pid_aw_pkg;

    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 31;
    localparam int SUM_W      = 32;
    localparam int DRIVE_W    = 32;
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_PROP   = 2'd0,
        CFG_GAIN_INTEG  = 2'd1,
        CFG_GAIN_DERIV  = 2'd2,
        CFG_INTEG_LIMIT = 2'd3
    } cfg_addr_t;

endpackage

>>> rtl/core/pid_aw_integ.sv
// ----------------------------------------------------------------------------
// pid_aw_integ
// Error, measured-change and clamped error sum; holds the error sum and the
// previous measured sample.
// ----------------------------------------------------------------------------
module pid_aw_integ
    import pid_aw_pkg::*;
#(
    parameter int SAMPLE_W = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [LIMIT_W-1:0]           integ_limit,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_W-1:0]   target,
    input  logic signed [SAMPLE_W-1:0]   measured,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_W:0]     err_out,
    output logic signed [SAMPLE_W:0]     derr_out,
    output logic signed [SUM_W-1:0]      sum_out
);

    localparam int ERR_W = SAMPLE_W + 1;
    localparam int RAW_W = SUM_W + 1;

    logic                       valid_reg;
    logic signed [SUM_W-1:0]    error_sum_reg;
    logic signed [SAMPLE_W-1:0] prev_meas_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    derr_reg;
    logic signed [SUM_W-1:0]    sum_reg;

    logic signed [ERR_W-1:0]    err_next;
    logic signed [ERR_W-1:0]    derr_next;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [RAW_W-1:0]    sum_raw;
    logic signed [RAW_W-1:0]    lim_pos;
    logic signed [RAW_W-1:0]    lim_neg;
    logic                       advance;

    assign in_ready  = !valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign err_out   = err_reg;
    assign derr_out  = derr_reg;
    assign sum_out   = sum_reg;

    always_comb begin
        err_next  = {target[SAMPLE_W-1], target} - {measured[SAMPLE_W-1], measured};
        derr_next = {prev_meas_reg[SAMPLE_W-1], prev_meas_reg}
                  - {measured[SAMPLE_W-1], measured};
        sum_raw   = {error_sum_reg[SUM_W-1], error_sum_reg}
                  + {{(RAW_W-ERR_W){err_next[ERR_W-1]}}, err_next};
        lim_pos   = {2'b00, integ_limit};
        lim_neg   = -lim_pos;
        if (sum_raw > lim_pos) begin
            sum_next = lim_pos[SUM_W-1:0];
        end else if (sum_raw < lim_neg) begin
            sum_next = lim_neg[SUM_W-1:0];
        end else begin
            sum_next = sum_raw[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            error_sum_reg <= '0;
            prev_meas_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (advance) begin
                error_sum_reg <= sum_next;
                prev_meas_reg <= measured;
            end
        end
        if (advance) begin
            err_reg  <= err_next;
            derr_reg <= derr_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

>>> rtl/core/pid_aw_gain.sv
// ----------------------------------------------------------------------------
// pid_aw_gain
// Gain products in one stage, then their sum scaled down by the gain
// fraction bits in a second stage.
// ----------------------------------------------------------------------------
module pid_aw_gain
    import pid_aw_pkg::*;
#(
    parameter int SAMPLE_W = 16,
    parameter int FRAC_W   = 8,
    parameter int ACC_W    = 50
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic signed [GAIN_W-1:0]   gain_prop,
    input  logic signed [GAIN_W-1:0]   gain_integ,
    input  logic signed [GAIN_W-1:0]   gain_deriv,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W:0]   err_in,
    input  logic signed [SAMPLE_W:0]   derr_in,
    input  logic signed [SUM_W-1:0]    sum_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [ACC_W-1:0]    scaled_out
);

    localparam int ERR_W = SAMPLE_W + 1;
    localparam int PE_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + SUM_W;

    logic                    prod_valid_reg;
    logic                    acc_valid_reg;
    logic signed [PE_W-1:0]  prod_p_reg;
    logic signed [PI_W-1:0]  prod_i_reg;
    logic signed [PE_W-1:0]  prod_d_reg;
    logic signed [ACC_W-1:0] scaled_reg;

    logic signed [PE_W-1:0]  prod_p_next;
    logic signed [PI_W-1:0]  prod_i_next;
    logic signed [PE_W-1:0]  prod_d_next;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] scaled_next;
    logic                    acc_ready;
    logic                    prod_advance;
    logic                    acc_advance;

    assign acc_ready    = !acc_valid_reg || out_ready;
    assign in_ready     = !prod_valid_reg || acc_ready;
    assign prod_advance = in_valid && in_ready;
    assign acc_advance  = prod_valid_reg && acc_ready;
    assign out_valid    = acc_valid_reg;
    assign scaled_out   = scaled_reg;

    always_comb begin
        prod_p_next = gain_prop * err_in;
        prod_i_next = gain_integ * sum_in;
        prod_d_next = gain_deriv * derr_in;
        acc_sum     = {{(ACC_W-PE_W){prod_p_reg[PE_W-1]}}, prod_p_reg}
                    + {{(ACC_W-PI_W){prod_i_reg[PI_W-1]}}, prod_i_reg}
                    + {{(ACC_W-PE_W){prod_d_reg[PE_W-1]}}, prod_d_reg};
        scaled_next = acc_sum >>> FRAC_W;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            acc_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (acc_ready) begin
                acc_valid_reg <= prod_valid_reg;
            end
        end
        if (prod_advance) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (acc_advance) begin
            scaled_reg <= scaled_next;
        end
    end

endmodule

>>> rtl/core/pid_aw_drive.sv
// ----------------------------------------------------------------------------
// pid_aw_drive
// Accumulated drive with 32-bit saturation; the result register doubles as
// the previous drive.
// ----------------------------------------------------------------------------
module pid_aw_drive
    import pid_aw_pkg::*;
#(
    parameter int ACC_W = 50
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [ACC_W-1:0]    scaled_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DRIVE_W-1:0]  drive,
    output logic                       drive_saturated
);

    localparam int TOT_W = ACC_W + 1;

    logic                      valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      sat_reg;

    logic signed [DRIVE_W-1:0] drive_next;
    logic                      sat_next;
    logic signed [TOT_W-1:0]   total;
    logic [TOT_W-DRIVE_W:0]    upper;
    logic                      advance;

    assign in_ready        = !valid_reg || out_ready;
    assign advance         = in_valid && in_ready;
    assign out_valid       = valid_reg;
    assign drive           = drive_reg;
    assign drive_saturated = sat_reg;

    always_comb begin
        total = {{(TOT_W-DRIVE_W){drive_reg[DRIVE_W-1]}}, drive_reg}
              + {scaled_in[ACC_W-1], scaled_in};
        upper = total[TOT_W-1:DRIVE_W-1];
        sat_next = !((&upper) || !(|upper));
        if (sat_next) begin
            drive_next = total[TOT_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                        : {1'b0, {(DRIVE_W-1){1'b1}}};
        end else begin
            drive_next = total[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            drive_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (advance) begin
                drive_reg <= drive_next;
                sat_reg   <= sat_next;
            end
        end
    end

endmodule

>>> rtl/core/pid_controller_antiwindup_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit
// Stages from input transfer to result valid: error/clamp stage,
// product stage, sum-and-scale stage, drive saturation register.
// Throughput: one item per cycle while m_tready is not held low; each stage advances independently.
// Reset: synchronous, active low; clears gains to zero, integral limit to
// its maximum, and the error sum, previous sample and previous drive to zero.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit
    import pid_aw_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [CFG_ADDR_W-1:0]            cfg_addr,
    input  logic [LIMIT_W-1:0]               cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // target, measured
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // drive
    output logic [DRIVE_W-1:0]               m_tdata,
    // drive_saturated
    output logic                             m_tuser
);

    localparam int ERR_W = SAMPLE_WIDTH + 1;
    localparam int PE_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + SUM_W;
    localparam int ACC_W = ((PI_W > PE_W) ? PI_W : PE_W) + 2;

    logic signed [GAIN_W-1:0] gain_prop_reg;
    logic signed [GAIN_W-1:0] gain_integ_reg;
    logic signed [GAIN_W-1:0] gain_deriv_reg;
    logic [LIMIT_W-1:0]       integ_limit_reg;

    logic                        integ_valid;
    logic                        gain_ready;
    logic signed [ERR_W-1:0]     err;
    logic signed [ERR_W-1:0]     derr;
    logic signed [SUM_W-1:0]     err_sum;
    logic                        gain_valid;
    logic                        drive_ready;
    logic signed [ACC_W-1:0]     scaled;
    logic signed [DRIVE_W-1:0]   drive;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg   <= '0;
            gain_integ_reg  <= '0;
            gain_deriv_reg  <= '0;
            integ_limit_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_addr_t'(cfg_addr))
                CFG_GAIN_PROP:   gain_prop_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_INTEG:  gain_integ_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_DERIV:  gain_deriv_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pid_aw_integ #(
        .SAMPLE_W (SAMPLE_WIDTH)
    ) u_integ (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .integ_limit (integ_limit_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .target      (s_tdata[SAMPLE_WIDTH-1:0]),
        .measured    (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .out_valid   (integ_valid),
        .out_ready   (gain_ready),
        .err_out     (err),
        .derr_out    (derr),
        .sum_out     (err_sum)
    );

    pid_aw_gain #(
        .SAMPLE_W (SAMPLE_WIDTH),
        .FRAC_W   (GAIN_FRAC_BITS),
        .ACC_W    (ACC_W)
    ) u_gain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gain_prop  (gain_prop_reg),
        .gain_integ (gain_integ_reg),
        .gain_deriv (gain_deriv_reg),
        .in_valid   (integ_valid),
        .in_ready   (gain_ready),
        .err_in     (err),
        .derr_in    (derr),
        .sum_in     (err_sum),
        .out_valid  (gain_valid),
        .out_ready  (drive_ready),
        .scaled_out (scaled)
    );

    pid_aw_drive #(
        .ACC_W (ACC_W)
    ) u_drive (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (gain_valid),
        .in_ready        (drive_ready),
        .scaled_in       (scaled),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .drive           (drive),
        .drive_saturated (m_tuser)
    );

    assign m_tdata = drive;

endmodule

>>> sim/pid_controller_antiwindup_unit_checker.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit_checker
// Watches the configuration port and both stream channels of the PID unit.
// Each accepted sample updates a private copy of the loop state and queues
// the expected drive. Each result transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit_checker
    import pid_aw_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [LIMIT_W-1:0]                  cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // target, measured
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // drive
    input  logic [DRIVE_W-1:0]                  m_tdata,
    // drive_saturated
    input  logic                                m_tuser,
    output int                                  pending,
    output int                                  fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clipped;
    } drive_result_t;

    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    logic signed [GAIN_W-1:0]       kp, ki, kd;
    logic        [LIMIT_W-1:0]      sum_bound;
    logic signed [SUM_W-1:0]        err_sum;
    logic signed [SAMPLE_WIDTH-1:0] last_meas;
    logic signed [DRIVE_W-1:0]      last_drive;

    drive_result_t expected_drives[$];
    int            errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic drive_result_t advance_loop(input logic signed [SAMPLE_WIDTH-1:0] tgt,
                                                   input logic signed [SAMPLE_WIDTH-1:0] meas);
        drive_result_t res;
        longint        err, dmeas, sum, lim, acc, drv;
        err   = longint'(tgt) - longint'(meas);
        dmeas = longint'(last_meas) - longint'(meas);
        lim   = longint'(sum_bound);
        sum   = longint'(err_sum) + err;
        if (sum > lim)
            sum = lim;
        if (sum < -lim)
            sum = -lim;
        acc = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * dmeas;
        drv = longint'(last_drive) + (acc >>> GAIN_FRAC_BITS);
        res.clipped = 1'b0;
        if (drv > DRIVE_MAX) begin
            drv = DRIVE_MAX;
            res.clipped = 1'b1;
        end else if (drv < DRIVE_MIN) begin
            drv = DRIVE_MIN;
            res.clipped = 1'b1;
        end
        res.drive  = drv[DRIVE_W-1:0];
        err_sum    = sum[SUM_W-1:0];
        last_meas  = meas;
        last_drive = res.drive;
        return res;
    endfunction

    always @(posedge aclk) begin
        drive_result_t want;
        if (!aresetn) begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            sum_bound  = '1;
            err_sum    = '0;
            last_meas  = '0;
            last_drive = '0;
            expected_drives.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_drives.size() == 0) begin
                    report_mismatch($sformatf("unexpected result drive=%0d sat=%0b",
                                              $signed(m_tdata), m_tuser));
                end else begin
                    want = expected_drives.pop_front();
                    if (m_tdata !== want.drive)
                        report_mismatch($sformatf("drive got %0d want %0d",
                                                  $signed(m_tdata), want.drive));
                    if (m_tuser !== want.clipped)
                        report_mismatch($sformatf("drive_saturated got %0b want %0b",
                                                  m_tuser, want.clipped));
                end
            end
            if (s_tvalid && s_tready)
                expected_drives.push_back(
                    advance_loop(s_tdata[SAMPLE_WIDTH-1:0],
                                 s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_GAIN_PROP:   kp = cfg_wdata[GAIN_W-1:0];
                    CFG_GAIN_INTEG:  ki = cfg_wdata[GAIN_W-1:0];
                    CFG_GAIN_DERIV:  kd = cfg_wdata[GAIN_W-1:0];
                    CFG_INTEG_LIMIT: sum_bound = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending <= expected_drives.size();
    end

endmodule

>>> sim/pid_controller_antiwindup_unit_tb.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit_tb
// Drives the PID unit through directed clamp and extreme-sample sets, then
// several gain and limit settings with random, tracking and extreme samples,
// mostly under random stalls on both channels. The checker beside the unit
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit_tb
    import pid_aw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = 16;
    localparam int DATA_W      = ((2*SW+7)/8)*8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LIMIT_MAX   = 32'h7FFFFFFF;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_GAIN_PROP;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DRIVE_W-1:0]    m_tdata;
    logic                  m_tuser;

    int pending;
    int fail_count;
    int cycle_count = 0;
    bit steady      = 1'b0;
    int setpoint    = 0;
    int plant       = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pid_controller_antiwindup_unit #(
        .SAMPLE_WIDTH  (SW),
        .GAIN_FRAC_BITS(8)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pid_controller_antiwindup_unit_checker #(
        .SAMPLE_WIDTH  (SW),
        .GAIN_FRAC_BITS(8)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .pending   (pending),
        .fail_count(fail_count)
    );

    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 21);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL pid_controller_antiwindup_unit");
            $finish;
        end
    end

    task automatic write_config(input int p, input int i, input int d, input int lim);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_GAIN_PROP;
        cfg_wdata <= {15'($urandom), 16'(p)};
        @(posedge aclk);
        cfg_addr  <= CFG_GAIN_INTEG;
        cfg_wdata <= {15'($urandom), 16'(i)};
        @(posedge aclk);
        cfg_addr  <= CFG_GAIN_DERIV;
        cfg_wdata <= {15'($urandom), 16'(d)};
        @(posedge aclk);
        cfg_addr  <= CFG_INTEG_LIMIT;
        cfg_wdata <= 31'(lim);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_sample(input int tgt, input int meas);
        while (!steady && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {SW'(meas), SW'(tgt)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every expected result has been seen
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic int extreme_sample();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    task automatic random_item();
        int pick;
        int tgt, meas;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            if ($urandom_range(0, 15) == 0)
                setpoint = int'($signed(16'($urandom)));
            plant = plant + (setpoint - plant) / 4 + int'($urandom_range(0, 64)) - 32;
            if (plant > 32767)
                plant = 32767;
            if (plant < -32768)
                plant = -32768;
            tgt  = setpoint;
            meas = plant;
        end else if (pick < 8) begin
            tgt  = int'($signed(16'($urandom)));
            meas = int'($signed(16'($urandom)));
        end else begin
            tgt  = extreme_sample();
            meas = extreme_sample();
        end
        send_sample(tgt, meas);
    endtask

    task automatic run_phase(input int p, input int i, input int d, input int lim,
                             input int count);
        write_config(p, i, d, lim);
        for (int k = 0; k < count; k++) begin
            if (k == count / 2)
                drain();
            random_item();
        end
        drain();
    endtask

    initial begin
        int dir_tgt[16]  = '{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768,
                             -32768, -32768, -32768, -32768, -32768, -32768, 0, -1};
        int dir_meas[16] = '{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767,
                             32767, 32767, 32767, 32767, 32767, 32767, 0, -1};
        int clamp_tgt[8]  = '{0, 1, 32767, 32767, -32768, -32768, -32768, 0};
        int clamp_meas[8] = '{1, 0, -32768, -32768, 32767, 32767, -32768, 0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // small limit, negative integral and derivative gains: clamp and floor rounding
        write_config(1, -3, -1, 5);
        foreach (clamp_tgt[k])
            send_sample(clamp_tgt[k], clamp_meas[k]);
        drain();

        // full-scale gains, full swing both ways
        write_config(32767, 32767, 32767, LIMIT_MAX);
        foreach (dir_tgt[k])
            send_sample(dir_tgt[k], dir_meas[k]);
        drain();

        run_phase(32767, 32767, 32767, LIMIT_MAX, 250);
        run_phase(-32768, -32768, -32768, 0, 250);
        run_phase(int'($urandom), int'($urandom), int'($urandom),
                  $urandom_range(0, 5000), 250);
        steady = 1'b1;
        run_phase(int'($urandom), int'($urandom), int'($urandom), LIMIT_MAX, 250);
        steady = 1'b0;
        run_phase(0, 0, 0, $urandom_range(0, LIMIT_MAX), 250);
        run_phase(int'($urandom), int'($urandom), int'($urandom),
                  $urandom_range(0, LIMIT_MAX), 250);

        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS pid_controller_antiwindup_unit");
        else
            $display("FAIL pid_controller_antiwindup_unit");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pid_aw_pkg.sv
rtl/core/pid_aw_integ.sv
rtl/core/pid_aw_gain.sv
rtl/core/pid_aw_drive.sv
rtl/core/pid_controller_antiwindup_unit.sv
sim/pid_controller_antiwindup_unit_checker.sv
sim/pid_controller_antiwindup_unit_tb.sv
